[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Types, widths and codes shared by the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int DATA_W          = 8;
    localparam int LEN_W           = 6;
    localparam int STATUS_W        = 3;
    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [STATUS_W-1:0] ST_PENDING    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERR_HEADER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERR_LENGTH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERR_CKS    = 3'd4;

    localparam logic REG_HEADER_BYTE = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    localparam logic [DATA_W-1:0] HEADER_RST  = 8'd0;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 6'd32;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN    = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_REPLAY = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] header_byte;
        logic [LEN_W-1:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [LEN_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [LEN_W-1:0]  rd_addr;
    } store_req_t;

endpackage

[hdl/fpr_rx_if.sv]
// ----------------------------------------------------------------------------
// fpr_rx_if
// Input byte channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface fpr_rx_if;
    logic                      valid;
    logic                      ready;
    logic [fpr_pkg::DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/fpr_res_if.sv]
// ----------------------------------------------------------------------------
// fpr_res_if
// Result channel: valid/ready handshake with status and payload fields.
// ----------------------------------------------------------------------------
interface fpr_res_if;
    logic                         valid;
    logic                         ready;
    logic [fpr_pkg::STATUS_W-1:0] status;
    logic                         payload_valid;
    logic [fpr_pkg::DATA_W-1:0]   payload_byte;
    logic [fpr_pkg::LEN_W-1:0]    payload_length;
    logic                         last;

    modport source (output valid, output status, output payload_valid,
                    output payload_byte, output payload_length, output last,
                    input ready);
    modport sink   (input valid, input status, input payload_valid,
                    input payload_byte, input payload_length, input last,
                    output ready);
endinterface

[hdl/fpr_cfg.sv]
// ----------------------------------------------------------------------------
// fpr_cfg
// APB register bank: header byte and maximum payload length.
// ----------------------------------------------------------------------------
module fpr_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fpr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fpr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output fpr_pkg::cfg_t                      cfg
);

    fpr_pkg::cfg_t cfg_reg;
    fpr_pkg::cfg_t cfg_next;
    logic          wr_xfer;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_xfer)
        begin
            case (reg_sel)
                fpr_pkg::REG_HEADER_BYTE: cfg_next.header_byte = pwdata[fpr_pkg::DATA_W-1:0];
                fpr_pkg::REG_MAX_LENGTH:  cfg_next.max_length  = pwdata[fpr_pkg::LEN_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte <= fpr_pkg::HEADER_RST;
            cfg_reg.max_length  <= fpr_pkg::MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            fpr_pkg::REG_HEADER_BYTE:
                prdata = {{(fpr_pkg::APB_DATA_W-fpr_pkg::DATA_W){1'b0}}, cfg_reg.header_byte};
            fpr_pkg::REG_MAX_LENGTH:
                prdata = {{(fpr_pkg::APB_DATA_W-fpr_pkg::LEN_W){1'b0}}, cfg_reg.max_length};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hdl/fpr_store.sv]
// ----------------------------------------------------------------------------
// fpr_store
// Payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpr_store
#(
    parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                          clk,
    input  fpr_pkg::store_req_t           req,
    output logic [fpr_pkg::DATA_W-1:0]    rd_data
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [fpr_pkg::DATA_W-1:0] mem [MAX_PAYLOAD];
    logic [fpr_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
        end
        // hold the last read word while the result side stalls
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/framed_packet_receiver.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Length-prefixed frame receiver with an 8-bit additive payload checksum.
// ----------------------------------------------------------------------------
// A single result is registered and shows in the cycle after its byte transfer.
// Throughput: one byte per cycle while the result register is free and no replay runs.
// A good checksum byte of a nonzero-length frame replays the N stored bytes: each is
// read into the registered memory read data, then loaded into the result register;
// no byte is taken meanwhile. Reset: rst_n is asynchronous, active low; control state
// and the result valid flag clear, the result fields and the payload memory do not.
`include "assert_macros.svh"

module framed_packet_receiver
#(
    parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    fpr_rx_if.sink                         rx,
    fpr_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fpr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fpr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam logic [fpr_pkg::DATA_W-1:0] MAX_LEN_B = fpr_pkg::DATA_W'(MAX_PAYLOAD);

    fpr_pkg::cfg_t       cfg;
    fpr_pkg::store_req_t st_req;
    logic [fpr_pkg::DATA_W-1:0] rd_data;

    fpr_pkg::phase_t            phase_reg, phase_next;
    logic [fpr_pkg::LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [fpr_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [fpr_pkg::DATA_W-1:0] sum_reg, sum_next;
    logic [fpr_pkg::LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                       pend_reg, pend_next;
    logic                       pend_last_reg, pend_last_next;

    logic                         out_valid_reg, out_valid_next;
    logic [fpr_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                         out_pvalid_reg, out_pvalid_next;
    logic [fpr_pkg::DATA_W-1:0]   out_byte_reg, out_byte_next;
    logic [fpr_pkg::LEN_W-1:0]    out_len_reg, out_len_next;
    logic                         out_last_reg, out_last_next;

    logic slot_free;
    logic rx_xfer;
    logic pend_load;
    logic rd_issue;
    logic cks_start;
    logic out_done_ok;

    fpr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpr_store #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_store
    (
        .clk     (clk),
        .req     (st_req),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || res.ready;
    assign rx.ready  = (phase_reg != fpr_pkg::PH_REPLAY) && slot_free;
    assign rx_xfer   = rx.valid && rx.ready;

    // memory word waiting for the result register
    assign pend_load = pend_reg && slot_free;
    assign rd_issue  = (phase_reg == fpr_pkg::PH_REPLAY) && (rd_idx_reg < exp_len_reg)
                       && (!pend_reg || pend_load);
    assign cks_start = rx_xfer && (phase_reg == fpr_pkg::PH_DATA) && (idx_reg >= exp_len_reg)
                       && (rx.rx_byte == sum_reg) && (exp_len_reg != '0);

    always_comb
    begin
        phase_next      = phase_reg;
        exp_len_next    = exp_len_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;

        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_pvalid_next = out_pvalid_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;

        st_req.wr_en    = 1'b0;
        st_req.wr_addr  = idx_reg;
        st_req.wr_data  = rx.rx_byte;
        st_req.rd_en    = rd_issue;
        st_req.rd_addr  = rd_idx_reg;

        if (rx_xfer)
        begin
            // single result by default; replay start overrides below
            out_valid_next  = 1'b1;
            out_status_next = fpr_pkg::ST_PENDING;
            out_pvalid_next = 1'b0;
            out_byte_next   = '0;
            out_len_next    = '0;
            out_last_next   = 1'b1;

            case (phase_reg)
                fpr_pkg::PH_HUNT:
                begin
                    if (rx.rx_byte == cfg.header_byte)
                    begin
                        phase_next = fpr_pkg::PH_LEN;
                    end
                    else
                    begin
                        out_status_next = fpr_pkg::ST_ERR_HEADER;
                    end
                end
                fpr_pkg::PH_LEN:
                begin
                    if ((rx.rx_byte > {2'b00, cfg.max_length}) || (rx.rx_byte > MAX_LEN_B))
                    begin
                        phase_next      = fpr_pkg::PH_HUNT;
                        out_status_next = fpr_pkg::ST_ERR_LENGTH;
                    end
                    else
                    begin
                        exp_len_next = rx.rx_byte[fpr_pkg::LEN_W-1:0];
                        sum_next     = '0;
                        idx_next     = '0;
                        phase_next   = fpr_pkg::PH_DATA;
                    end
                end
                fpr_pkg::PH_DATA:
                begin
                    if (idx_reg >= exp_len_reg)
                    begin
                        phase_next = fpr_pkg::PH_HUNT;
                        if (rx.rx_byte != sum_reg)
                        begin
                            out_status_next = fpr_pkg::ST_ERR_CKS;
                        end
                        else if (exp_len_reg == '0)
                        begin
                            out_status_next = fpr_pkg::ST_DONE;
                        end
                        else
                        begin
                            // no result now: replay the stored payload
                            phase_next     = fpr_pkg::PH_REPLAY;
                            out_valid_next = out_valid_reg && !res.ready;
                            rd_idx_next    = '0;
                            pend_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        st_req.wr_en = 1'b1;
                        sum_next     = sum_reg + rx.rx_byte;
                        idx_next     = idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = fpr_pkg::PH_HUNT;
                end
            endcase
        end

        if (phase_reg == fpr_pkg::PH_REPLAY)
        begin
            if (pend_load)
            begin
                out_valid_next  = 1'b1;
                out_status_next = fpr_pkg::ST_DONE;
                out_pvalid_next = 1'b1;
                out_byte_next   = rd_data;
                out_len_next    = exp_len_reg;
                out_last_next   = pend_last_reg;
                pend_next       = 1'b0;
                if (pend_last_reg)
                begin
                    phase_next = fpr_pkg::PH_HUNT;
                end
            end
            if (rd_issue)
            begin
                pend_next      = 1'b1;
                pend_last_next = ((rd_idx_reg + 1'b1) == exp_len_reg);
                rd_idx_next    = rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fpr_pkg::PH_HUNT;
            exp_len_reg   <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            exp_len_reg   <= exp_len_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_pvalid_reg <= out_pvalid_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = out_status_reg;
    assign res.payload_valid  = out_pvalid_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.payload_length = out_len_reg;
    assign res.last           = out_last_reg;

    assign out_done_ok = (res.status == fpr_pkg::ST_DONE) && (res.payload_length == exp_len_reg);

    `ASSERT_NEXT(a_cks_enters_replay, cks_start, phase_reg == fpr_pkg::PH_REPLAY)
    `ASSERT_IMPL(a_pend_only_in_replay, pend_reg, phase_reg == fpr_pkg::PH_REPLAY)
    `ASSERT_IMPL(a_no_write_in_replay, st_req.wr_en, phase_reg != fpr_pkg::PH_REPLAY)
    `ASSERT_IMPL(a_payload_is_done, res.valid && res.payload_valid, out_done_ok)

endmodule

[test/framed_packet_receiver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_test
// Drives a byte stream of headers, lengths, payloads and checksums into the
// receiver, tracks the framing state alongside it, and checks every result
// transfer field by field. A short table of hand-picked bytes and register
// writes runs first, then randomized frames over several register settings.
// ----------------------------------------------------------------------------
module framed_packet_receiver_test;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 18;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [fpr_pkg::STATUS_W-1:0] status;
        logic                         payload_valid;
        logic [fpr_pkg::DATA_W-1:0]   payload_byte;
        logic [fpr_pkg::LEN_W-1:0]    payload_length;
        logic                         last;
    } result_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        logic                         reg_sel;
        logic [fpr_pkg::DATA_W-1:0]   value;
        bit                           typed;
        logic [fpr_pkg::STATUS_W-1:0] status;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [fpr_pkg::APB_ADDR_W-1:0] paddr;
    logic [fpr_pkg::APB_DATA_W-1:0] pwdata;
    logic [fpr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    fpr_rx_if  rx_bus();
    fpr_res_if res_bus();

    framed_packet_receiver dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_bus),
        .res     (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Framing state tracked alongside the block
    fpr_pkg::phase_t            frame_phase;
    logic [fpr_pkg::DATA_W-1:0] frame_bytes [fpr_pkg::MAX_PAYLOAD_DEF];
    logic [fpr_pkg::LEN_W-1:0]  frame_len;
    logic [fpr_pkg::LEN_W-1:0]  fill_count;
    logic [fpr_pkg::DATA_W-1:0] sum_acc;
    logic [fpr_pkg::DATA_W-1:0] cfg_header;
    logic [fpr_pkg::LEN_W-1:0]  cfg_max_len;

    result_t expected_results [$];
    int      mismatch_count = 0;
    bit      steady_flow    = 1'b0;
    bit      hold_off_req   = 1'b0;

    row_t directed_rows [$] = '{
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_ERR_HEADER},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b1, fpr_pkg::ST_DONE},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd33, 1'b1, fpr_pkg::ST_ERR_LENGTH},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd2,  1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd1,  1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h80, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h7F, 1'b1, fpr_pkg::ST_ERR_CKS},
        '{ROW_WRITE, fpr_pkg::REG_MAX_LENGTH,  8'd63, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_WRITE, fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'h00, 1'b1, fpr_pkg::ST_ERR_HEADER},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd63, 1'b1, fpr_pkg::ST_ERR_LENGTH},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_ERR_LENGTH},
        '{ROW_WRITE, fpr_pkg::REG_MAX_LENGTH,  8'd0,  1'b0, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd1,  1'b1, fpr_pkg::ST_ERR_LENGTH},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'hFF, 1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd0,  1'b1, fpr_pkg::ST_PENDING},
        '{ROW_BYTE,  fpr_pkg::REG_HEADER_BYTE, 8'd0,  1'b1, fpr_pkg::ST_DONE}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t single_result(input logic [fpr_pkg::STATUS_W-1:0] status);
        result_t r;
        r = '0;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

    // Advance the framing state by one received byte and append its results
    function automatic void frame_step(input logic [fpr_pkg::DATA_W-1:0] b,
                                       ref result_t outq [$]);
        result_t r;
        case (frame_phase)
            fpr_pkg::PH_HUNT:
            begin
                if (b == cfg_header)
                begin
                    frame_phase = fpr_pkg::PH_LEN;
                    outq.push_back(single_result(fpr_pkg::ST_PENDING));
                end
                else
                begin
                    outq.push_back(single_result(fpr_pkg::ST_ERR_HEADER));
                end
            end
            fpr_pkg::PH_LEN:
            begin
                if (b > cfg_max_len || b > fpr_pkg::MAX_PAYLOAD_DEF)
                begin
                    frame_phase = fpr_pkg::PH_HUNT;
                    outq.push_back(single_result(fpr_pkg::ST_ERR_LENGTH));
                end
                else
                begin
                    frame_len   = b[fpr_pkg::LEN_W-1:0];
                    fill_count  = '0;
                    sum_acc     = '0;
                    frame_phase = fpr_pkg::PH_DATA;
                    outq.push_back(single_result(fpr_pkg::ST_PENDING));
                end
            end
            default:
            begin
                if (fill_count >= frame_len)
                begin
                    frame_phase = fpr_pkg::PH_HUNT;
                    if (b != sum_acc)
                    begin
                        outq.push_back(single_result(fpr_pkg::ST_ERR_CKS));
                    end
                    else if (frame_len == 0)
                    begin
                        outq.push_back(single_result(fpr_pkg::ST_DONE));
                    end
                    else
                    begin
                        for (int k = 0; k < frame_len; k++)
                        begin
                            r.status         = fpr_pkg::ST_DONE;
                            r.payload_valid  = 1'b1;
                            r.payload_byte   = frame_bytes[k];
                            r.payload_length = frame_len;
                            r.last           = (k == frame_len - 1);
                            outq.push_back(r);
                        end
                    end
                end
                else
                begin
                    frame_bytes[fill_count] = b;
                    sum_acc    = sum_acc + b;
                    fill_count = fill_count + 1'b1;
                    outq.push_back(single_result(fpr_pkg::ST_PENDING));
                end
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [fpr_pkg::DATA_W-1:0] b, input bit typed,
                             input logic [fpr_pkg::STATUS_W-1:0] typed_status);
        int unsigned gap;
        result_t     fresh [$];
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            rx_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_bus.valid   = 1'b1;
        rx_bus.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        frame_step(b, fresh);
        if (typed)
            expected_results.push_back(single_result(typed_status));
        else
            foreach (fresh[i])
                expected_results.push_back(fresh[i]);
        @(negedge clk);
    endtask

    // Hold the input until every expected result is out and the block is quiet
    task automatic drain;
        rx_bus.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [fpr_pkg::DATA_W-1:0] value);
        paddr   = {reg_sel, 2'b00};
        pwdata  = {{(fpr_pkg::APB_DATA_W-fpr_pkg::DATA_W){1'b0}}, value};
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == fpr_pkg::REG_HEADER_BYTE)
            cfg_header = value;
        else
            cfg_max_len = value[fpr_pkg::LEN_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_frame(output int sent);
        int                         unsigned choice;
        int                         unsigned limit;
        int                         unsigned len;
        logic [fpr_pkg::DATA_W-1:0] b;
        logic [fpr_pkg::DATA_W-1:0] cks;
        limit  = (cfg_max_len > fpr_pkg::MAX_PAYLOAD_DEF) ? fpr_pkg::MAX_PAYLOAD_DEF
                                                          : cfg_max_len;
        choice = $urandom_range(0, 9);
        sent   = 0;
        if (choice == 0)
        begin
            send_byte(fpr_pkg::DATA_W'($urandom_range(0, 255)), 1'b0, fpr_pkg::ST_PENDING);
            sent = 1;
        end
        else if (choice == 1)
        begin
            send_byte(cfg_header, 1'b0, fpr_pkg::ST_PENDING);
            send_byte(fpr_pkg::DATA_W'($urandom_range(limit + 1, 255)), 1'b0,
                      fpr_pkg::ST_PENDING);
            sent = 2;
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                len = limit;
            else
                len = $urandom_range(0, (limit < 6) ? limit : 6);
            send_byte(cfg_header, 1'b0, fpr_pkg::ST_PENDING);
            send_byte(fpr_pkg::DATA_W'(len), 1'b0, fpr_pkg::ST_PENDING);
            cks = '0;
            for (int i = 0; i < len; i++)
            begin
                b   = fpr_pkg::DATA_W'($urandom_range(0, 255));
                cks = cks + b;
                send_byte(b, 1'b0, fpr_pkg::ST_PENDING);
            end
            if ($urandom_range(0, 5) == 0)
                cks = cks + fpr_pkg::DATA_W'($urandom_range(1, 255));
            send_byte(cks, 1'b0, fpr_pkg::ST_PENDING);
            sent = len + 3;
        end
    endtask

    // Result side: random stalls, and one long hold-off on request
    initial
    begin
        int unsigned wait_n;
        res_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            wait_n = steady_flow ? 0 : $urandom_range(0, 4);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                wait_n       = HOLD_OFF_CYCLES;
            end
            if (wait_n != 0)
            begin
                res_bus.ready = 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            res_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_bus.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.status, res_bus.payload_valid, res_bus.payload_byte,
                    res_bus.payload_length, res_bus.last};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected transfer: status %0d valid %0b byte %02h len %0d last %0b",
                             got.status, got.payload_valid, got.payload_byte,
                             got.payload_length, got.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: expected status %0d valid %0b byte %02h len %0d ",
                                  "last %0b, got status %0d valid %0b byte %02h len %0d last %0b"},
                                 want.status, want.payload_valid, want.payload_byte,
                                 want.payload_length, want.last,
                                 got.status, got.payload_valid, got.payload_byte,
                                 got.payload_length, got.last);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  sent;
        int  phase_items;
        int  random_items;
        bit  pressure_done;
        rst_n          = 1'b0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        frame_phase    = fpr_pkg::PH_HUNT;
        frame_len      = '0;
        fill_count     = '0;
        sum_acc        = '0;
        cfg_header     = fpr_pkg::HEADER_RST;
        cfg_max_len    = fpr_pkg::MAX_LEN_RST;
        random_items   = 0;
        pressure_done  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
            begin
                send_byte(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].status);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case ($urandom_range(0, 3))
                0:       write_reg(fpr_pkg::REG_HEADER_BYTE, 8'h00);
                1:       write_reg(fpr_pkg::REG_HEADER_BYTE, 8'hFF);
                default: write_reg(fpr_pkg::REG_HEADER_BYTE,
                                   fpr_pkg::DATA_W'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(fpr_pkg::REG_MAX_LENGTH, 8'd0);
                1:       write_reg(fpr_pkg::REG_MAX_LENGTH, 8'd63);
                2:       write_reg(fpr_pkg::REG_MAX_LENGTH, 8'd32);
                default: write_reg(fpr_pkg::REG_MAX_LENGTH,
                                   fpr_pkg::DATA_W'($urandom_range(1, 32)));
            endcase
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                // Stall the result side once while bytes keep coming
                if (!pressure_done && random_items >= 40)
                begin
                    pressure_done = 1'b1;
                    hold_off_req  = 1'b1;
                end
                send_frame(sent);
                phase_items  += sent;
                random_items += sent;
            end
        end

        rx_bus.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/fpr_pkg.sv
hdl/fpr_rx_if.sv
hdl/fpr_res_if.sv
hdl/fpr_cfg.sv
hdl/fpr_store.sv
hdl/framed_packet_receiver.sv
test/framed_packet_receiver_test.sv
